@@ hw/rtl/gst_pkg.sv @@
// ----------------------------------------------------------------------------
// gst_pkg
// Shared types, sizes and codes for the generational slot table.
// ----------------------------------------------------------------------------
package gst_pkg;

  // table geometry
  localparam int SLOT_COUNT   = 64;
  localparam int GEN_BITS     = 32;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int USE_W        = $clog2(SLOT_COUNT + 1);
  localparam int HANDLE_SLOT_W = 6;
  localparam int HANDLE_GEN_W = 32;
  localparam int COUNT_W      = 32;

  // live-bit search runs over groups of eight slots
  localparam int GROUP_SIZE   = 8;
  localparam int GROUPS       = SLOT_COUNT / GROUP_SIZE;
  localparam int GROUP_W      = $clog2(GROUPS);
  localparam int MEMBER_W     = $clog2(GROUP_SIZE);

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CHECK = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_PICK = 2'd1,
    CS_EXEC = 2'd2
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pick;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/generational_slot_table.sv @@
// ----------------------------------------------------------------------------
// generational_slot_table
// Slot table handing out (slot, generation) handles: allocate, free, check
// and index query, with a running count of rejected frees.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  command   start / busy       func, handle_slot, handle_generation
//  result    done (one cycle)   status, out_slot, out_generation,
//                               invalid_requests
//
// A beat is taken on start while busy is low. Free, check and query go through
// accept and execute, with one generation RAM read; allocate adds a dead-slot
// pick over registered per-group search results between the two.
// done pulses the cycle after execute, when busy is already low again.
// Synchronous reset clears live bits, fill count and the reject counter; no
// clearing pass is needed. Results cannot be stalled.
//
module generational_slot_table
  import gst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic [HANDLE_SLOT_W-1:0] handle_slot,
  input  logic [HANDLE_GEN_W-1:0]  handle_generation,
  output logic                     done,
  output logic [1:0]               status,
  output logic [HANDLE_SLOT_W-1:0] out_slot,
  output logic [HANDLE_GEN_W-1:0]  out_generation,
  output logic [COUNT_W-1:0]       invalid_requests
);

  ctrl_cmd_t cmd;

  gst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .busy  (busy),
    .cmd   (cmd)
  );

  gst_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .func              (func),
    .handle_slot       (handle_slot),
    .handle_generation (handle_generation),
    .done              (done),
    .status            (status),
    .out_slot          (out_slot),
    .out_generation    (out_generation),
    .invalid_requests  (invalid_requests)
  );

endmodule

@@ hw/rtl/gst_ram.sv @@
// ----------------------------------------------------------------------------
// gst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/gst_ctrl.sv @@
// ----------------------------------------------------------------------------
// gst_ctrl
// Sequencer: accept, optional slot pick for allocate, execute.
// ----------------------------------------------------------------------------
module gst_ctrl
  import gst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  func,
  output logic        busy,
  output ctrl_cmd_t   cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (start) begin
          state_next = (func_t'(func) == FN_ALLOC) ? CS_PICK : CS_EXEC;
        end
      end
      CS_PICK: state_next = CS_EXEC;
      CS_EXEC: state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      CS_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      CS_PICK: cmd.pick = 1'b1;
      CS_EXEC: cmd.exec = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ hw/rtl/gst_dp.sv @@
// ----------------------------------------------------------------------------
// gst_dp
// Datapath: live bits, fill count, generation RAM, dead-slot search,
// handle checks and the result registers.
// ----------------------------------------------------------------------------
module gst_dp
  import gst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  input  logic [1:0]               func,
  input  logic [HANDLE_SLOT_W-1:0] handle_slot,
  input  logic [HANDLE_GEN_W-1:0]  handle_generation,
  output logic                     done,
  output logic [1:0]               status,
  output logic [HANDLE_SLOT_W-1:0] out_slot,
  output logic [HANDLE_GEN_W-1:0]  out_generation,
  output logic [COUNT_W-1:0]       invalid_requests
);

  // control state
  logic [SLOT_COUNT-1:0] live;
  logic [USE_W-1:0]      in_use;
  logic [COUNT_W-1:0]    invalid_count;

  // latched beat
  func_t                 func_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [HANDLE_GEN_W-1:0] gen_q;

  // search results
  logic [GROUPS-1:0]     grp_any;
  logic [MEMBER_W-1:0]   grp_idx [GROUPS];
  logic [GROUPS-1:0]     grp_any_c;
  logic [MEMBER_W-1:0]   grp_idx_c [GROUPS];
  logic [SLOT_W-1:0]     pick;
  logic                  append;
  logic                  full;
  logic [SLOT_W-1:0]     pick_c;
  logic                  append_c;
  logic                  full_c;
  logic                  found_c;

  // RAM
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [GEN_BITS-1:0]   ram_wdata;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [GEN_BITS-1:0]   ram_rdata;

  // execute
  logic                  in_range;
  logic                  slot_live;
  logic                  handle_ok;
  logic [GEN_BITS-1:0]   old_gen;
  logic [GEN_BITS-1:0]   new_gen;
  status_t               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [HANDLE_GEN_W-1:0] res_gen;

  // per-group lowest dead slot among those in use
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_c[g] = 1'b0;
      grp_idx_c[g] = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (!live[g * GROUP_SIZE + b] &&
            (USE_W'(g * GROUP_SIZE + b) < in_use)) begin
          grp_any_c[g] = 1'b1;
          grp_idx_c[g] = MEMBER_W'(b);
        end
      end
    end
  end

  // lowest group with a dead slot, else append, else full
  always_comb begin
    found_c = 1'b0;
    pick_c  = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found_c = 1'b1;
        pick_c  = {GROUP_W'(g), grp_idx[g]};
      end
    end
    append_c = 1'b0;
    full_c   = 1'b0;
    if (!found_c) begin
      if (in_use < USE_W'(SLOT_COUNT)) begin
        append_c = 1'b1;
        pick_c   = in_use[SLOT_W-1:0];
      end else begin
        full_c = 1'b1;
      end
    end
  end

  // beat capture and search registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= func_t'(func);
      slot_q  <= handle_slot[SLOT_W-1:0];
      gen_q   <= handle_generation;
      grp_any <= grp_any_c;
      grp_idx <= grp_idx_c;
    end
    if (cmd.pick) begin
      pick   <= pick_c;
      append <= append_c;
      full   <= full_c;
    end
  end

  // generation store, read at accept (handle) or at pick (allocate)
  assign ram_re    = cmd.accept | cmd.pick;
  assign ram_raddr = cmd.pick ? pick_c : handle_slot[SLOT_W-1:0];

  gst_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handle checks and result selection
  always_comb begin
    in_range   = USE_W'(slot_q) < in_use;
    slot_live  = live[slot_q];
    handle_ok  = (gen_q != '0) && in_range && slot_live &&
                 (HANDLE_GEN_W'(ram_rdata) == gen_q);
    // slots never appended have never been written: generation zero
    old_gen    = append ? '0 : ram_rdata;
    new_gen    = old_gen + GEN_BITS'(1);
    if (new_gen == '0) begin
      new_gen = GEN_BITS'(1);
    end
    ram_we     = 1'b0;
    ram_waddr  = pick;
    ram_wdata  = new_gen;
    res_status = ST_INVALID;
    res_slot   = '0;
    res_gen    = '0;
    case (func_q)
      FN_ALLOC: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ram_we     = cmd.exec;
          res_status = ST_OK;
          res_slot   = pick;
          res_gen    = HANDLE_GEN_W'(new_gen);
        end
      end
      FN_FREE, FN_CHECK: begin
        if (handle_ok) begin
          res_status = ST_OK;
          res_slot   = slot_q;
          res_gen    = gen_q;
        end
      end
      FN_QUERY: begin
        if (in_range && slot_live) begin
          res_status = ST_OK;
          res_slot   = slot_q;
          res_gen    = HANDLE_GEN_W'(ram_rdata);
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  // table state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      live          <= '0;
      in_use        <= '0;
      invalid_count <= '0;
    end else if (cmd.exec) begin
      case (func_q)
        FN_ALLOC: begin
          if (!full) begin
            live[pick] <= 1'b1;
            if (append) begin
              in_use <= in_use + USE_W'(1);
            end
          end
        end
        FN_FREE: begin
          if (handle_ok) begin
            live[slot_q] <= 1'b0;
          end else begin
            invalid_count <= invalid_count + COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= res_status;
      out_slot       <= HANDLE_SLOT_W'(res_slot);
      out_generation <= res_gen;
    end
  end

  assign invalid_requests = invalid_count;

endmodule
